>>> hdl/jtab_pkg.sv
// ----------------------------------------------------------------------------
// jtab_pkg: job table shared definitions
// table sizing, command and status codes and the packed entry layout
// ----------------------------------------------------------------------------
`default_nettype none

package jtab_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ID_W      = 16;
  localparam int PID_W     = 31;
  localparam int FUNC_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int OUT_CNT_W = 8;

  // highest id that may ever be handed out
  localparam logic [ID_W-1:0] ID_TOP = '1;

  // command codes
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PID_W-1:0] pid;
    logic             bg;
    logic             stp;
  } entry_t;

endpackage

`default_nettype wire

>>> hdl/job_table_with_id_allocation_unit.sv
// ----------------------------------------------------------------------------
// job_table_with_id_allocation_unit: packed job table with id allocation
// insertion-ordered table in one single-port-read memory, with a scan/shift
// sequencer serving insert, lookup, remove and highest-stopped query
// ----------------------------------------------------------------------------
// scan: lookup walks the entries upwards and query walks them downwards, one memory
//   read a cycle; remove scans as for lookup, then moves each later entry one place down
// throughput: one command at a time, next beat taken once the result is registered
// reset: synchronous active-low rst_n clears count, top id and control, not memory
`default_nettype none

module job_table_with_id_allocation_unit (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // command channel
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  [jtab_pkg::FUNC_W-1:0]           in_func,
  input  wire  [jtab_pkg::ID_W-1:0]             in_job_id,
  input  wire  [jtab_pkg::PID_W-1:0]            in_proc_id,
  input  wire                                   in_background,
  input  wire                                   in_stopped,
  // result channel
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [jtab_pkg::STATUS_W-1:0]         out_status,
  output logic [jtab_pkg::ID_W-1:0]             out_found_id,
  output logic [jtab_pkg::PID_W-1:0]            out_found_proc_id,
  output logic                                  out_found_background,
  output logic                                  out_found_stopped,
  output logic [jtab_pkg::OUT_CNT_W-1:0]        out_entry_count
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_TAIL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // control state
  logic [2:0]                      state_r,  state_nxt;
  logic [jtab_pkg::CNT_W-1:0]      count_r,  count_nxt;   // entries in use
  logic [jtab_pkg::ID_W-1:0]       top_r,    top_nxt;     // id of the last entry, zero when empty
  logic [jtab_pkg::FUNC_W-1:0]     func_r,   func_nxt;
  logic [jtab_pkg::ID_W-1:0]       key_r,    key_nxt;
  logic [jtab_pkg::CNT_W-1:0]      ptr_r,    ptr_nxt;     // scan / shift pointer
  logic                            pv_r,     pv_nxt;      // a read is in flight
  logic [jtab_pkg::IDX_W-1:0]      pidx_r,   pidx_nxt;    // index tied to that read
  logic                            moved_r,  moved_nxt;   // remove moved an entry
  logic [jtab_pkg::ID_W-1:0]       last_r,   last_nxt;    // id of last moved entry
  logic                            out_valid_r, out_valid_nxt;

  // pending result, held until the output register is free
  logic [jtab_pkg::STATUS_W-1:0]   res_status_r, res_status_nxt;
  jtab_pkg::entry_t                res_entry_r,  res_entry_nxt;
  logic [jtab_pkg::CNT_W-1:0]      res_count_r,  res_count_nxt;

  // output payload registers
  logic [jtab_pkg::STATUS_W-1:0]   out_status_r;
  jtab_pkg::entry_t                out_entry_r;
  logic [jtab_pkg::OUT_CNT_W-1:0]  out_count_r;
  logic                            out_load;

  // table memory, one read and one write port
  jtab_pkg::entry_t                mem [jtab_pkg::TABLE_DEPTH];
  jtab_pkg::entry_t                rd_data_r;
  logic                            mem_re;
  logic [jtab_pkg::IDX_W-1:0]      rd_addr;
  logic                            mem_we;
  logic [jtab_pkg::IDX_W-1:0]      wr_addr;
  jtab_pkg::entry_t                wr_data;

  // scan helpers
  logic                            scan_up;
  logic                            scan_more;
  logic                            scan_hit;
  logic [jtab_pkg::CNT_W-1:0]      ptr_inc;
  logic [jtab_pkg::CNT_W-1:0]      ptr_dec;
  logic [jtab_pkg::CNT_W-1:0]      cnt_dec;
  logic [jtab_pkg::CNT_W-1:0]      cnt_dec2;
  jtab_pkg::entry_t                new_entry;

  assign ptr_inc  = ptr_r + 1'b1;
  assign ptr_dec  = ptr_r - 1'b1;
  assign cnt_dec  = count_r - 1'b1;
  assign cnt_dec2 = count_r - 2'd2;

  // lookup and remove walk upwards by id, the stopped query walks downwards
  assign scan_up   = (func_r != jtab_pkg::FN_QUERY);
  assign scan_more = scan_up ? (ptr_r < count_r) : (ptr_r != '0);
  assign scan_hit  = pv_r && (scan_up ? (rd_data_r.id == key_r) : rd_data_r.stp);

  // entry built by an insert: next id after the top one
  assign new_entry = '{id:  jtab_pkg::ID_W'(top_r + 1'b1),
                       pid: in_proc_id,
                       bg:  in_background,
                       stp: in_stopped};

  // commands are taken only between operations
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    top_nxt        = top_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    ptr_nxt        = ptr_r;
    pv_nxt         = pv_r;
    pidx_nxt       = pidx_r;
    moved_nxt      = moved_r;
    last_nxt       = last_r;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    res_count_nxt  = res_count_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_load       = 1'b0;
    mem_re         = 1'b0;
    rd_addr        = '0;
    mem_we         = 1'b0;
    wr_addr        = '0;
    wr_data        = rd_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          key_nxt   = in_job_id;
          pv_nxt    = 1'b0;
          moved_nxt = 1'b0;
          unique case (in_func) inside
            jtab_pkg::FN_INSERT: begin
              state_nxt     = S_DONE;
              res_count_nxt = count_r;
              res_entry_nxt = '0;
              // full table is checked before the id space
              if (count_r == jtab_pkg::CNT_W'(jtab_pkg::TABLE_DEPTH)) begin
                res_status_nxt = jtab_pkg::ST_FULL;
              end else if (top_r == jtab_pkg::ID_TOP) begin
                res_status_nxt = jtab_pkg::ST_EXHAUSTED;
              end else begin
                mem_we         = 1'b1;
                wr_addr        = count_r[jtab_pkg::IDX_W-1:0];
                wr_data        = new_entry;
                count_nxt      = count_r + 1'b1;
                top_nxt        = new_entry.id;
                res_status_nxt = jtab_pkg::ST_OK;
                res_entry_nxt  = new_entry;
                res_count_nxt  = count_r + 1'b1;
              end
            end
            jtab_pkg::FN_LOOKUP, jtab_pkg::FN_REMOVE: begin
              ptr_nxt   = '0;
              state_nxt = S_SCAN;
            end
            default: begin
              ptr_nxt   = count_r;
              state_nxt = S_SCAN;
            end
          endcase
        end
      end

      S_SCAN: begin
        // one read issued and one compare done every cycle
        if (scan_hit) begin
          res_status_nxt = jtab_pkg::ST_OK;
          res_entry_nxt  = rd_data_r;
          res_count_nxt  = count_r;
          pv_nxt         = 1'b0;
          if (func_r == jtab_pkg::FN_REMOVE) begin
            ptr_nxt   = jtab_pkg::CNT_W'(pidx_r);
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (scan_more) begin
          mem_re   = 1'b1;
          rd_addr  = scan_up ? ptr_r[jtab_pkg::IDX_W-1:0] : ptr_dec[jtab_pkg::IDX_W-1:0];
          pv_nxt   = 1'b1;
          pidx_nxt = rd_addr;
          ptr_nxt  = scan_up ? ptr_inc : ptr_dec;
        end else begin
          // last candidate checked without a hit
          pv_nxt         = 1'b0;
          res_status_nxt = jtab_pkg::ST_NOTFOUND;
          res_entry_nxt  = '0;
          res_count_nxt  = count_r;
          state_nxt      = S_DONE;
        end
      end

      S_SHIFT: begin
        // write back the entry read last cycle one place lower
        if (pv_r) begin
          mem_we    = 1'b1;
          wr_addr   = pidx_r;
          wr_data   = rd_data_r;
          last_nxt  = rd_data_r.id;
          moved_nxt = 1'b1;
        end
        if (ptr_inc < count_r) begin
          mem_re   = 1'b1;
          rd_addr  = ptr_inc[jtab_pkg::IDX_W-1:0];
          pv_nxt   = 1'b1;
          pidx_nxt = ptr_r[jtab_pkg::IDX_W-1:0];
          ptr_nxt  = ptr_inc;
        end else if (pv_r) begin
          pv_nxt = 1'b0;
        end else begin
          count_nxt     = cnt_dec;
          res_count_nxt = cnt_dec;
          if (moved_r) begin
            top_nxt   = last_r;
            state_nxt = S_DONE;
          end else if (count_r == jtab_pkg::CNT_W'(1)) begin
            top_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            // removed the tail: fetch the new last entry for its id
            mem_re    = 1'b1;
            rd_addr   = cnt_dec2[jtab_pkg::IDX_W-1:0];
            state_nxt = S_TAIL;
          end
        end
      end

      S_TAIL: begin
        top_nxt   = rd_data_r.id;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      top_r       <= '0;
      pv_r        <= 1'b0;
      moved_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      top_r       <= top_nxt;
      pv_r        <= pv_nxt;
      moved_r     <= moved_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    ptr_r        <= ptr_nxt;
    pidx_r       <= pidx_nxt;
    last_r       <= last_nxt;
    res_status_r <= res_status_nxt;
    res_entry_r  <= res_entry_nxt;
    res_count_r  <= res_count_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_entry_r  <= res_entry_r;
      out_count_r  <= jtab_pkg::OUT_CNT_W'(res_count_r);
    end
  end

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_found_id         = out_entry_r.id;
  assign out_found_proc_id    = out_entry_r.pid;
  assign out_found_background = out_entry_r.bg;
  assign out_found_stopped    = out_entry_r.stp;
  assign out_entry_count      = out_count_r;

  // count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= jtab_pkg::CNT_W'(jtab_pkg::TABLE_DEPTH))
    else $error("entry count above table depth");

  // an empty table always has top id cleared
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (top_r == '0))
    else $error("top id not cleared with empty table");

  // each shift write lands one place below the read issued the cycle before
  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && pv_r) |->
      (jtab_pkg::IDX_W'(wr_addr + 1'b1) == $past(rd_addr)))
    else $error("shift write address out of step with read");

  // a full-table refusal reports the whole depth as the count
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == jtab_pkg::ST_FULL) |->
      (out_count_r == jtab_pkg::OUT_CNT_W'(jtab_pkg::TABLE_DEPTH)))
    else $error("full status with wrong entry count");

endmodule

`default_nettype wire

>>> test/tb_job_table_with_id_allocation_unit.sv
// ----------------------------------------------------------------------------
// tb_job_table_with_id_allocation_unit: self-checking bench for the job table
// a queue-fed driver and a result monitor around the unit; every accepted
// command beat is run through a behavioural job table in the bench and the
// reply it gives is compared with the result beat, field by field and in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb_job_table_with_id_allocation_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF   = 5;
  localparam int RST_CYCLES = 8;
  // tail wait after the final drain, sized from the table depth, for stray beats
  localparam int TAIL_WAIT  = 2 * jtab_pkg::TABLE_DEPTH + 40;
  localparam int PHASE_ITEMS = 160;

  // one command beat as the bench keeps it
  typedef struct packed {
    logic [jtab_pkg::FUNC_W-1:0] func;
    logic [jtab_pkg::ID_W-1:0]   job_id;
    logic [jtab_pkg::PID_W-1:0]  proc_id;
    logic                        bg;
    logic                        stp;
  } job_cmd_t;

  // one result beat; field order matches the result ports
  typedef struct packed {
    logic [jtab_pkg::STATUS_W-1:0]  status;
    logic [jtab_pkg::ID_W-1:0]      id;
    logic [jtab_pkg::PID_W-1:0]     pid;
    logic                           bg;
    logic                           stp;
    logic [jtab_pkg::OUT_CNT_W-1:0] cnt;
  } job_reply_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [jtab_pkg::FUNC_W-1:0]    in_func = jtab_pkg::FN_QUERY;
  logic [jtab_pkg::ID_W-1:0]      in_job_id = '0;
  logic [jtab_pkg::PID_W-1:0]     in_proc_id = '0;
  logic                           in_background = 1'b0;
  logic                           in_stopped = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [jtab_pkg::STATUS_W-1:0]  out_status;
  logic [jtab_pkg::ID_W-1:0]      out_found_id;
  logic [jtab_pkg::PID_W-1:0]     out_found_proc_id;
  logic                           out_found_background;
  logic                           out_found_stopped;
  logic [jtab_pkg::OUT_CNT_W-1:0] out_entry_count;

  // commands waiting to be sent; the head stays until its beat is accepted
  job_cmd_t   job_cmds[$];
  // replies predicted for accepted commands, oldest first
  job_reply_t job_replies[$];

  // behavioural copy of the table, in insertion order
  jtab_pkg::entry_t          tbl[jtab_pkg::TABLE_DEPTH];
  int                        tbl_cnt = 0;
  logic [jtab_pkg::ID_W-1:0] tbl_top = '0;

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int mismatch_cnt = 0;
  // occupancy the random stimulus leans towards, moved now and then
  int fill_goal = 64;

  job_table_with_id_allocation_unit uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_func              (in_func),
    .in_job_id            (in_job_id),
    .in_proc_id           (in_proc_id),
    .in_background        (in_background),
    .in_stopped           (in_stopped),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_found_id         (out_found_id),
    .out_found_proc_id    (out_found_proc_id),
    .out_found_background (out_found_background),
    .out_found_stopped    (out_found_stopped),
    .out_entry_count      (out_entry_count)
  );

  always #CLK_HALF clk = ~clk;

  // apply one command to the bench table and return the reply it must give
  function automatic job_reply_t job_table_apply(job_cmd_t c);
    job_reply_t       r;
    jtab_pkg::entry_t e;
    int               at;
    r = '0;
    r.status = jtab_pkg::ST_OK;
    e = '0;
    at = -1;
    case (c.func)
      jtab_pkg::FN_INSERT: begin
        // a full table wins over an exhausted id space
        if (tbl_cnt >= jtab_pkg::TABLE_DEPTH) begin
          r.status = jtab_pkg::ST_FULL;
        end else if (tbl_top == jtab_pkg::ID_TOP) begin
          r.status = jtab_pkg::ST_EXHAUSTED;
        end else begin
          tbl_top = tbl_top + 1'b1;
          e = '{id: tbl_top, pid: c.proc_id, bg: c.bg, stp: c.stp};
          tbl[tbl_cnt] = e;
          tbl_cnt++;
        end
      end
      jtab_pkg::FN_LOOKUP, jtab_pkg::FN_REMOVE: begin
        for (int k = 0; k < tbl_cnt && at < 0; k++)
          if (tbl[k].id == c.job_id) at = k;
        if (at < 0) begin
          r.status = jtab_pkg::ST_NOTFOUND;
        end else begin
          e = tbl[at];
          if (c.func == jtab_pkg::FN_REMOVE) begin
            // close the gap, then the top id follows the last entry left
            for (int k = at; k + 1 < tbl_cnt; k++) tbl[k] = tbl[k + 1];
            tbl_cnt--;
            tbl_top = (tbl_cnt == 0) ? '0 : tbl[tbl_cnt - 1].id;
          end
        end
      end
      default: begin
        // highest-index stopped entry, index 0 included
        for (int k = tbl_cnt - 1; k >= 0 && at < 0; k--)
          if (tbl[k].stp) at = k;
        if (at < 0) r.status = jtab_pkg::ST_NOTFOUND;
        else e = tbl[at];
      end
    endcase
    // e stays zero on any failing status
    r.id  = e.id;
    r.pid = e.pid;
    r.bg  = e.bg;
    r.stp = e.stp;
    r.cnt = jtab_pkg::OUT_CNT_W'(tbl_cnt);
    return r;
  endfunction

  task automatic flag_error(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // driver: a beat leaves the queue only when accepted, and a stalled beat is
  // held as it is; otherwise the next beat goes out unless the sender idles
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : cmd_driver
    bit       take;
    bit       present;
    job_cmd_t c;
    if (rst_n) begin
      take = in_valid && !in_stall;
      if (take) job_replies.push_back(job_table_apply(job_cmds.pop_front()));
      if (in_valid && !take) present = 1'b1;
      else present = (job_cmds.size() != 0) && ($urandom_range(99) >= src_idle_pct);
      if (present) begin
        c = job_cmds[0];
        in_valid      <= 1'b1;
        in_func       <= c.func;
        in_job_id     <= c.job_id;
        in_proc_id    <= c.proc_id;
        in_background <= c.bg;
        in_stopped    <= c.stp;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check each accepted result beat against the oldest prediction,
  // then pick the stall for the next cycle
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : reply_monitor
    job_reply_t got;
    job_reply_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_status, out_found_id, out_found_proc_id, out_found_background,
               out_found_stopped, out_entry_count};
        if (job_replies.size() == 0) begin
          flag_error($sformatf("result beat with nothing expected: st=%0d id=%0d",
                               got.status, got.id));
        end else begin
          want = job_replies.pop_front();
          if (got !== want)
            flag_error($sformatf({"result mismatch: expected st=%0d id=%0d pid=%0h ",
                                  "bg=%0b stp=%0b cnt=%0d, got st=%0d id=%0d pid=%0h ",
                                  "bg=%0b stp=%0b cnt=%0d"},
                                 want.status, want.id, want.pid, want.bg, want.stp,
                                 want.cnt, got.status, got.id, got.pid, got.bg,
                                 got.stp, got.cnt));
        end
      end
      out_stall <= ($urandom_range(99) < snk_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(logic [jtab_pkg::FUNC_W-1:0] f, logic [jtab_pkg::ID_W-1:0] id,
                           logic [jtab_pkg::PID_W-1:0] pid, logic bg, logic stp);
    job_cmds.push_back('{func: f, job_id: id, proc_id: pid, bg: bg, stp: stp});
  endtask

  // insert with random content; the pid leans on its extremes now and then
  task automatic queue_insert_rand();
    logic [jtab_pkg::PID_W-1:0] pid;
    case ($urandom_range(7))
      0:       pid = '0;
      1:       pid = '1;
      default: pid = jtab_pkg::PID_W'($urandom);
    endcase
    queue_cmd(jtab_pkg::FN_INSERT, jtab_pkg::ID_W'($urandom), pid, 1'($urandom),
              1'($urandom));
  endtask

  // wait on the falling edge so the bench table is settled when read;
  // with all_done the predicted replies must have arrived too
  task automatic drain(bit all_done);
    while (job_cmds.size() != 0 || (all_done && job_replies.size() != 0))
      @(negedge clk);
  endtask

  // a short burst built from the current table: mostly live ids, some noise
  task automatic random_burst(output int n);
    int                        pick;
    int                        sel;
    logic [jtab_pkg::ID_W-1:0] id;
    n = $urandom_range(1, 6);
    if ($urandom_range(15) == 0) fill_goal = $urandom_range(0, jtab_pkg::TABLE_DEPTH + 4);
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < ((tbl_cnt < fill_goal) ? 60 : 20)) begin
        queue_insert_rand();
      end else begin
        if (tbl_cnt != 0 && $urandom_range(9) != 0) id = tbl[$urandom_range(tbl_cnt - 1)].id;
        else id = jtab_pkg::ID_W'($urandom);
        sel = $urandom_range(9);
        if (sel < 4)
          queue_cmd(jtab_pkg::FN_REMOVE, id, jtab_pkg::PID_W'($urandom), 1'($urandom),
                    1'($urandom));
        else if (sel < 7)
          queue_cmd(jtab_pkg::FN_LOOKUP, id, jtab_pkg::PID_W'($urandom), 1'($urandom),
                    1'($urandom));
        else
          queue_cmd(jtab_pkg::FN_QUERY, id, jtab_pkg::PID_W'($urandom), 1'($urandom),
                    1'($urandom));
      end
    end
  endtask

  task automatic random_phase(int items);
    int issued;
    int n;
    issued = 0;
    while (issued < items) begin
      random_burst(n);
      issued += n;
      drain(1'b0);
    end
    drain(1'b1);
  endtask

  // top the table up until an insert is refused as full, then remove the head
  // entry so that every later entry moves down one place
  task automatic fill_table();
    drain(1'b0);
    repeat (jtab_pkg::TABLE_DEPTH - tbl_cnt + 1) queue_insert_rand();
    drain(1'b0);
    queue_cmd(jtab_pkg::FN_LOOKUP, tbl_top, '0, 1'b0, 1'b0);
    queue_cmd(jtab_pkg::FN_QUERY, '0, '0, 1'b0, 1'b0);
    queue_cmd(jtab_pkg::FN_REMOVE, tbl[0].id, '0, 1'b0, 1'b0);
    queue_insert_rand();
    queue_insert_rand();
    drain(1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed beats on an empty table, ids follow from the sequence
    queue_cmd(jtab_pkg::FN_QUERY,  16'hffff, 31'h7fffffff, 1'b1, 1'b1);  // nothing stopped
    queue_cmd(jtab_pkg::FN_LOOKUP, 16'd0,    31'd0,        1'b0, 1'b0);  // empty table
    queue_cmd(jtab_pkg::FN_REMOVE, 16'hffff, 31'd0,        1'b0, 1'b0);  // empty table
    queue_cmd(jtab_pkg::FN_INSERT, 16'hffff, 31'd0,        1'b0, 1'b0);  // id 1
    queue_cmd(jtab_pkg::FN_INSERT, 16'h0000, 31'h7fffffff, 1'b1, 1'b1);  // id 2
    queue_cmd(jtab_pkg::FN_INSERT, 16'h5555, 31'h55555555, 1'b1, 1'b0);  // id 3
    queue_cmd(jtab_pkg::FN_INSERT, 16'haaaa, 31'h2aaaaaaa, 1'b0, 1'b1);  // id 4
    queue_cmd(jtab_pkg::FN_LOOKUP, 16'd1,    31'd0,        1'b0, 1'b0);
    queue_cmd(jtab_pkg::FN_LOOKUP, 16'd2,    31'd0,        1'b0, 1'b0);
    queue_cmd(jtab_pkg::FN_LOOKUP, 16'd0,    31'd0,        1'b0, 1'b0);  // id 0 never given
    queue_cmd(jtab_pkg::FN_QUERY,  16'd0,    31'd0,        1'b0, 1'b0);  // id 4, last index
    queue_cmd(jtab_pkg::FN_REMOVE, 16'd4,    31'd0,        1'b0, 1'b0);  // last entry, top 3
    queue_cmd(jtab_pkg::FN_QUERY,  16'd0,    31'd0,        1'b0, 1'b0);  // id 2
    queue_cmd(jtab_pkg::FN_INSERT, 16'd0,    31'h12345678, 1'b0, 1'b0);  // id 4 again
    queue_cmd(jtab_pkg::FN_REMOVE, 16'd1,    31'd0,        1'b0, 1'b0);  // head entry, shift
    queue_cmd(jtab_pkg::FN_LOOKUP, 16'd2,    31'd0,        1'b0, 1'b0);
    queue_cmd(jtab_pkg::FN_LOOKUP, 16'd4,    31'd0,        1'b0, 1'b0);
    queue_cmd(jtab_pkg::FN_REMOVE, 16'd4,    31'd0,        1'b0, 1'b0);
    queue_cmd(jtab_pkg::FN_REMOVE, 16'd3,    31'd0,        1'b0, 1'b0);
    queue_cmd(jtab_pkg::FN_QUERY,  16'd0,    31'd0,        1'b0, 1'b0);  // stopped at index 0
    queue_cmd(jtab_pkg::FN_REMOVE, 16'd2,    31'd0,        1'b0, 1'b0);  // empty, top id 0
    queue_cmd(jtab_pkg::FN_INSERT, 16'd0,    31'd1,        1'b1, 1'b0);  // id 1 again
    queue_cmd(jtab_pkg::FN_REMOVE, 16'd1,    31'd0,        1'b0, 1'b0);
    queue_cmd(jtab_pkg::FN_REMOVE, 16'd1,    31'd0,        1'b0, 1'b0);  // already gone
    drain(1'b1);

    // random traffic with free-flowing channels, then a full table
    random_phase(PHASE_ITEMS);
    fill_table();

    // sender mostly idle
    src_idle_pct = 82;
    snk_stall_pct = 0;
    random_phase(PHASE_ITEMS);

    // receiver mostly stalling
    src_idle_pct = 0;
    snk_stall_pct = 82;
    random_phase(PHASE_ITEMS);

    // both sides pausing now and then
    src_idle_pct = 28;
    snk_stall_pct = 28;
    random_phase(PHASE_ITEMS);

    // let any stray result beat show up before the verdict
    drain(1'b1);
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #100_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

>>> job_table_with_id_allocation_unit.f
hdl/jtab_pkg.sv
hdl/job_table_with_id_allocation_unit.sv
test/tb_job_table_with_id_allocation_unit.sv
